>>> rtl/assert_macros.svh
// Assertion helpers. They refer to clk and arst_n of the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define STLI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define STLI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/stli_pkg.sv
package stli_pkg;

	localparam int KEY_W    = 16;
	localparam int VAL_W    = 16;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;

	localparam int DEF_MAX_POINTS = 32;

	// Quotient magnitude always fits 16 bits, so the divider runs 16 steps.
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Item modes
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_EXACT   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INTERP  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

	// Result value sources
	localparam logic [2:0] VS_ZERO   = 3'd0;
	localparam logic [2:0] VS_LAST   = 3'd1;
	localparam logic [2:0] VS_RD     = 3'd2;
	localparam logic [2:0] VS_PREV   = 3'd3;
	localparam logic [2:0] VS_INTERP = 3'd4;

	typedef struct packed {
		logic                take;       // latch input transaction
		logic                ld_init;    // idx <= count, read entry count-1
		logic                ld_shift;   // move read entry up one, idx--
		logic                ld_put;     // write new point at idx, count++
		logic                clr;        // empty the table
		logic                q_init;     // idx <= 0, read entry 0
		logic                q_next;     // prev <= read entry, idx++
		logic                setup;      // latch interpolation operands
		logic                mul;        // product register
		logic                div_init;
		logic                div_step;
		logic                res_load;
		logic [2:0]          res_src;
		logic [STATUS_W-1:0] res_status;
		logic                emit;       // move result into output register
	} stli_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              full;
		logic              count_zero;
		logic              rd_gt;     // read key > query/load key
		logic              rd_eq;
		logic              prev_eq;
		logic              idx_zero;
		logic              idx_one;
		logic              idx_last;
		logic              div_last;
		logic              out_free;
	} stli_sts_t;

endpackage

>>> rtl/sorted_table_linear_interpolation_unit.sv
// A load shifts larger entries up to insert the point (insertion shift); clear, a full
// table and a query on an empty table answer at once; other queries scan, then may interpolate.
// Throughput: one transaction at a time; the next is taken the cycle after the
// result enters the output register, so a stalled output does not hold the input.
// Reset (arst_n, async, active low): table empty, last value zero, output idle.
// Table contents are not cleared by reset; entries are only read below the count.
`include "assert_macros.svh"

module sorted_table_linear_interpolation_unit #(
	parameter int MAX_POINTS = stli_pkg::DEF_MAX_POINTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [stli_pkg::MODE_W-1:0]       mode,
	input  logic signed [stli_pkg::KEY_W-1:0] angle,
	input  logic signed [stli_pkg::VAL_W-1:0] coefficient,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [stli_pkg::VAL_W-1:0] value,
	output logic [stli_pkg::STATUS_W-1:0]     status
);

	// Controller walks the one-read, one-write table memory one entry per cycle:
	//  - load: shifts larger keys up from the top, then drops the new point in
	//    (equal keys stay ahead of the new one, so load order is kept)
	//  - query: scans upward until the first key above the query key; the
	//    entry before it is the last equal key or the lower breakpoint
	//  - interpolation: one 16x16 multiply, then a 16-step restoring divide
	//    on magnitudes, sign applied afterwards (truncates toward zero)
	// Results sit in a staging register until the output register is free.
	stli_pkg::stli_cmd_t cmd;
	stli_pkg::stli_sts_t sts;

	stli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	stli_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.angle       (angle),
		.coefficient (coefficient),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.value       (value),
		.status      (status)
	);

	// An accepted transaction closes the input until its result is out.
	`STLI_ASSERT_NXT(a_take_stalls, in_valid && !in_stall, in_stall)
	// A result only moves into a free output register.
	`STLI_ASSERT_IMP(a_emit_free, cmd.emit, !out_valid || !out_stall)
	// Never write a point past the table depth.
	`STLI_ASSERT_IMP(a_put_not_full, cmd.ld_put, !sts.full)
	// The input reopens only right after a result was handed on.
	`STLI_ASSERT_IMP(a_reopen_after_emit, $fell(in_stall), $past(cmd.emit))

endmodule

>>> rtl/stli_ctrl.sv
module stli_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  stli_pkg::stli_sts_t sts,
	output stli_pkg::stli_cmd_t cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_LD_CMP   = 4'd2;
	localparam logic [3:0] S_LD_PUT   = 4'd3;
	localparam logic [3:0] S_Q_SCAN   = 4'd4;
	localparam logic [3:0] S_MUL      = 4'd5;
	localparam logic [3:0] S_DINIT    = 4'd6;
	localparam logic [3:0] S_DIV      = 4'd7;
	localparam logic [3:0] S_FIN      = 4'd8;
	localparam logic [3:0] S_EMIT     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.mode)
					stli_pkg::MODE_LOAD: begin
						if (sts.full) begin
							cmd.res_load   = 1'b1;
							cmd.res_src    = stli_pkg::VS_ZERO;
							cmd.res_status = stli_pkg::ST_FULL;
							state_d        = S_EMIT;
						end else begin
							cmd.ld_init = 1'b1;
							state_d     = sts.count_zero ? S_LD_PUT : S_LD_CMP;
						end
					end
					stli_pkg::MODE_QUERY: begin
						if (sts.count_zero) begin
							cmd.res_load   = 1'b1;
							cmd.res_src    = stli_pkg::VS_LAST;
							cmd.res_status = stli_pkg::ST_RANGE;
							state_d        = S_EMIT;
						end else begin
							cmd.q_init = 1'b1;
							state_d    = S_Q_SCAN;
						end
					end
					stli_pkg::MODE_CLEAR: begin
						cmd.clr        = 1'b1;
						cmd.res_load   = 1'b1;
						cmd.res_src    = stli_pkg::VS_ZERO;
						cmd.res_status = stli_pkg::ST_CLEARED;
						state_d        = S_EMIT;
					end
					default: begin
						cmd.res_load   = 1'b1;
						cmd.res_src    = stli_pkg::VS_LAST;
						cmd.res_status = stli_pkg::ST_RANGE;
						state_d        = S_EMIT;
					end
				endcase
			end
			S_LD_CMP: begin
				if (sts.rd_gt) begin
					cmd.ld_shift = 1'b1;
					if (sts.idx_one) begin
						state_d = S_LD_PUT;
					end
				end else begin
					cmd.ld_put     = 1'b1;
					cmd.res_load   = 1'b1;
					cmd.res_src    = stli_pkg::VS_ZERO;
					cmd.res_status = stli_pkg::ST_LOADED;
					state_d        = S_EMIT;
				end
			end
			S_LD_PUT: begin
				cmd.ld_put     = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_src    = stli_pkg::VS_ZERO;
				cmd.res_status = stli_pkg::ST_LOADED;
				state_d        = S_EMIT;
			end
			S_Q_SCAN: begin
				if (sts.rd_gt) begin
					if (sts.idx_zero) begin
						cmd.res_load   = 1'b1;
						cmd.res_src    = stli_pkg::VS_LAST;
						cmd.res_status = stli_pkg::ST_RANGE;
						state_d        = S_EMIT;
					end else if (sts.prev_eq) begin
						cmd.res_load   = 1'b1;
						cmd.res_src    = stli_pkg::VS_PREV;
						cmd.res_status = stli_pkg::ST_EXACT;
						state_d        = S_EMIT;
					end else begin
						cmd.setup = 1'b1;
						state_d   = S_MUL;
					end
				end else if (sts.idx_last) begin
					cmd.res_load = 1'b1;
					if (sts.rd_eq) begin
						cmd.res_src    = stli_pkg::VS_RD;
						cmd.res_status = stli_pkg::ST_EXACT;
					end else begin
						cmd.res_src    = stli_pkg::VS_LAST;
						cmd.res_status = stli_pkg::ST_RANGE;
					end
					state_d = S_EMIT;
				end else begin
					cmd.q_next = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.res_load   = 1'b1;
				cmd.res_src    = stli_pkg::VS_INTERP;
				cmd.res_status = stli_pkg::ST_INTERP;
				state_d        = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/stli_dp.sv
module stli_dp #(
	parameter int MAX_POINTS = stli_pkg::DEF_MAX_POINTS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  stli_pkg::stli_cmd_t                  cmd,
	output stli_pkg::stli_sts_t                  sts,
	input  logic [stli_pkg::MODE_W-1:0]          mode,
	input  logic signed [stli_pkg::KEY_W-1:0]    angle,
	input  logic signed [stli_pkg::VAL_W-1:0]    coefficient,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic signed [stli_pkg::VAL_W-1:0]    value,
	output logic [stli_pkg::STATUS_W-1:0]        status
);

	localparam int KW = stli_pkg::KEY_W;
	localparam int VW = stli_pkg::VAL_W;
	localparam int EW = KW + VW;
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int NW = 2 * VW;

	// Table memory: key in the upper half, value in the lower half.
	logic [EW-1:0] mem_q [MAX_POINTS];
	logic [EW-1:0] rd_q;
	logic [CW-1:0] rd_idx;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic          wr_en;

	logic [stli_pkg::MODE_W-1:0] mode_q;
	logic signed [KW-1:0] key_q;
	logic signed [VW-1:0] coef_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic [EW-1:0]        prev_q;
	logic signed [VW-1:0] last_q;

	logic [KW-1:0]        dk_q;
	logic [KW-1:0]        dd_q;
	logic [VW-1:0]        dvabs_q;
	logic                 neg_q;
	logic signed [VW-1:0] va_q;
	logic [NW-1:0]        prod_q;
	logic [VW-1:0]        rem_q;
	logic [VW-1:0]        dq_q;
	logic [stli_pkg::DIV_CNT_W-1:0] cnt_q;

	logic signed [VW-1:0]             res_value_q;
	logic [stli_pkg::STATUS_W-1:0]    res_status_q;
	logic                             out_valid_q;
	logic signed [VW-1:0]             out_value_q;
	logic [stli_pkg::STATUS_W-1:0]    out_status_q;

	logic signed [KW-1:0] rd_key;
	logic signed [VW-1:0] rd_val;
	logic signed [KW-1:0] prev_key;
	logic signed [VW-1:0] prev_val;
	logic signed [KW:0]   dk_w;
	logic signed [KW:0]   dd_w;
	logic signed [VW:0]   dv_w;
	logic signed [VW:0]   dvabs_w;
	logic [VW:0]          trial;
	logic [VW:0]          trial_sub;
	logic signed [VW:0]   q_w;
	logic signed [VW+1:0] sum_w;
	logic signed [VW-1:0] interp_w;
	logic signed [VW-1:0] res_value_d;
	logic                 upd_last;

	assign rd_key   = rd_q[EW-1:VW];
	assign rd_val   = rd_q[VW-1:0];
	assign prev_key = prev_q[EW-1:VW];
	assign prev_val = prev_q[VW-1:0];

	// Read address for the next cycle
	always_comb begin
		rd_idx = idx_q;
		if (cmd.ld_init) begin
			rd_idx = count_q - CW'(1);
		end else if (cmd.ld_shift) begin
			rd_idx = idx_q - CW'(2);
		end else if (cmd.q_init) begin
			rd_idx = '0;
		end else if (cmd.q_next) begin
			rd_idx = idx_q + CW'(1);
		end
	end
	assign rd_addr = rd_idx[AW-1:0];

	assign wr_en   = cmd.ld_shift | cmd.ld_put;
	assign wr_addr = idx_q[AW-1:0];
	assign wr_data = cmd.ld_shift ? rd_q : {key_q, coef_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// Interpolation operands
	assign dk_w    = {key_q[KW-1], key_q} - {prev_key[KW-1], prev_key};
	assign dd_w    = {rd_key[KW-1], rd_key} - {prev_key[KW-1], prev_key};
	assign dv_w    = {rd_val[VW-1], rd_val} - {prev_val[VW-1], prev_val};
	assign dvabs_w = dv_w[VW] ? -dv_w : dv_w;

	// Restoring divide step
	assign trial     = {rem_q, dq_q[VW-1]};
	assign trial_sub = trial - {1'b0, dd_q};

	// Sign, offset and saturate
	assign q_w   = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
	assign sum_w = {{2{va_q[VW-1]}}, va_q} + {q_w[VW], q_w};
	always_comb begin
		if (sum_w[VW+1:VW-1] == 3'b000 || sum_w[VW+1:VW-1] == 3'b111) begin
			interp_w = sum_w[VW-1:0];
		end else if (sum_w[VW+1]) begin
			interp_w = {1'b1, {(VW-1){1'b0}}};
		end else begin
			interp_w = {1'b0, {(VW-1){1'b1}}};
		end
	end

	always_comb begin
		upd_last    = 1'b0;
		res_value_d = '0;
		case (cmd.res_src)
			stli_pkg::VS_LAST: begin
				res_value_d = last_q;
			end
			stli_pkg::VS_RD: begin
				res_value_d = rd_val;
				upd_last    = 1'b1;
			end
			stli_pkg::VS_PREV: begin
				res_value_d = prev_val;
				upd_last    = 1'b1;
			end
			stli_pkg::VS_INTERP: begin
				res_value_d = interp_w;
				upd_last    = 1'b1;
			end
			default: begin
				res_value_d = '0;
			end
		endcase
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= mode;
			key_q  <= angle;
			coef_q <= coefficient;
		end
		if (cmd.ld_init) begin
			idx_q <= count_q;
		end else if (cmd.ld_shift) begin
			idx_q <= idx_q - CW'(1);
		end else if (cmd.q_init) begin
			idx_q <= '0;
		end else if (cmd.q_next) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.q_next) begin
			prev_q <= rd_q;
		end
		if (cmd.setup) begin
			dk_q    <= dk_w[KW-1:0];
			dd_q    <= dd_w[KW-1:0];
			dvabs_q <= dvabs_w[VW-1:0];
			neg_q   <= dv_w[VW];
			va_q    <= prev_val;
		end
		if (cmd.mul) begin
			prod_q <= NW'(dk_q) * NW'(dvabs_q);
		end
		if (cmd.div_init) begin
			rem_q <= prod_q[NW-1:VW];
			dq_q  <= prod_q[VW-1:0];
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial_sub[VW]) begin
				rem_q <= trial_sub[VW-1:0];
				dq_q  <= {dq_q[VW-2:0], 1'b1};
			end else begin
				rem_q <= trial[VW-1:0];
				dq_q  <= {dq_q[VW-2:0], 1'b0};
			end
			cnt_q <= cnt_q + stli_pkg::DIV_CNT_W'(1);
		end
		if (cmd.res_load) begin
			res_value_q  <= res_value_d;
			res_status_q <= cmd.res_status;
		end
		if (cmd.emit) begin
			out_value_q  <= res_value_q;
			out_status_q <= res_status_q;
		end
	end

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				count_q <= '0;
			end else if (cmd.ld_put) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.res_load && upd_last) begin
				last_q <= res_value_d;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.mode       = mode_q;
	assign sts.full       = (count_q == CW'(MAX_POINTS));
	assign sts.count_zero = (count_q == '0);
	assign sts.rd_gt      = (rd_key > key_q);
	assign sts.rd_eq      = (rd_key == key_q);
	assign sts.prev_eq    = (prev_key == key_q);
	assign sts.idx_zero   = (idx_q == '0);
	assign sts.idx_one    = (idx_q == CW'(1));
	assign sts.idx_last   = (idx_q == count_q - CW'(1));
	assign sts.div_last   = (cnt_q == stli_pkg::DIV_CNT_W'(stli_pkg::DIV_STEPS - 1));
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign value     = out_value_q;
	assign status    = out_status_q;

endmodule
